// ===== src/twomc_pkg.sv =====
// Shared types and constants for the three-way ordinal merge check unit.
package twomc_pkg;

  localparam int CNT_W      = 7;
  localparam int REG_W      = 7;
  localparam int PORT_ORD_W = 32;
  localparam int RESULT_CAP = 64;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] LIST_NONE = 2'd3;

  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_ELEMENT    = 3'd0,
    ST_EMPTY_OK   = 3'd1,
    ST_LIST_LIMIT = 3'd2,
    ST_AGG_LIMIT  = 3'd3,
    ST_ORDER      = 3'd4,
    ST_DUPLICATE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_A,
    REG_MAX_B,
    REG_MAX_C,
    REG_MAX_TOTAL
  } reg_index_t;

  typedef enum logic {
    OP_LOAD,
    OP_FINISH
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic [1:0]             sel;
    logic [PORT_ORD_W-1:0]  ord;
  } op_t;

  typedef struct packed {
    logic [REG_W-1:0] max_a;
    logic [REG_W-1:0] max_b;
    logic [REG_W-1:0] max_c;
    logic [REG_W-1:0] max_total;
  } limits_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_REPORT
  } back_state_t;

  typedef enum logic {
    PASS_CHECK,
    PASS_EMIT
  } pass_t;

endpackage

// ===== src/three_way_ordinal_merge_check_unit.sv =====
// Top level of the three-way ordinal merge check unit.
//
// Input channel (in_valid / in_stall): each beat is a load (command 0) that
// appends ordinal to the list given by list_select, or a finish (command 1).
// Beats enter a two-entry queue; in_stall rises only while that queue is full.
// A load is applied as it leaves the queue. A finish walks the three stores
// twice: a check pass for shared ordinals and an emit pass, each taking one
// store read and one compare of the three list heads per merged element; the
// emit pass gives one result beat per merged element. A failed limit or order
// check, or an empty frame, gives a single beat; a shared ordinal gives a
// single beat when the check pass meets it. No input is taken from the queue
// while a finish is in progress.
// Output channel (out_valid / out_stall): one output register; while stalled
// it holds its beat and the merge engine waits.
// Reset (rst, synchronous) empties the queue, clears the frame counts and sets
// all four limit registers to 64. Store contents are not cleared.
module three_way_ordinal_merge_check_unit import twomc_pkg::*; #(
  parameter int LIST_DEPTH   = 64,
  parameter int ORDINAL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [1:0]            list_select,
  input  logic [PORT_ORD_W-1:0] ordinal,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [PORT_ORD_W-1:0] merged_ordinal,
  output logic                  last
);

  limits_t limits;
  logic    q_valid;
  op_t     q_op;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_a     <= REG_RESET;
      limits.max_b     <= REG_RESET;
      limits.max_c     <= REG_RESET;
      limits.max_total <= REG_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_A:     limits.max_a     <= cfg_data;
        REG_MAX_B:     limits.max_b     <= cfg_data;
        REG_MAX_C:     limits.max_c     <= cfg_data;
        REG_MAX_TOTAL: limits.max_total <= cfg_data;
      endcase
    end
  end

  twomc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .list_select (list_select),
    .ordinal     (ordinal),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .q_pop       (q_pop)
  );

  twomc_back #(
    .LIST_DEPTH   (LIST_DEPTH),
    .ORDINAL_BITS (ORDINAL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .limits         (limits),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .merged_ordinal (merged_ordinal),
    .last           (last)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled with empty queue");

  a_report_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ELEMENT) |-> (last && merged_ordinal == '0))
    else $error("non-element result not final or carries an ordinal");
`endif

endmodule

// ===== src/twomc_front.sv =====
// Front end: accepts input beats, drops unknown-list loads, queues decoded operations.
module twomc_front import twomc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [1:0]            list_select,
  input  logic [PORT_ORD_W-1:0] ordinal,
  output logic                  q_valid,
  output op_t                   q_op,
  input  logic                  q_pop
);

  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  op_t        slot [2];
  op_t        op_in;
  logic       keep;
  logic       push;

  assign in_stall = (fill == 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_op     = slot[rd_ptr];

  always_comb begin
    op_in.kind = (command == CMD_FINISH) ? OP_FINISH : OP_LOAD;
    op_in.sel  = list_select;
    op_in.ord  = ordinal;
    keep       = (command == CMD_FINISH) || (list_select != LIST_NONE);
    push       = in_valid && !in_stall && keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= op_in;
    end
  end

endmodule

// ===== src/twomc_back.sv =====
// Back end: list stores, frame checks, two-pass merge engine and output register.
module twomc_back import twomc_pkg::*; #(
  parameter int LIST_DEPTH   = 64,
  parameter int ORDINAL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  limits_t               limits,
  input  logic                  q_valid,
  input  op_t                   q_op,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [PORT_ORD_W-1:0] merged_ordinal,
  output logic                  last
);

  localparam int ORD_W = (ORDINAL_BITS < PORT_ORD_W) ? ORDINAL_BITS : PORT_ORD_W;
  localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TOT_W = CNT_W + 2;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(LIST_DEPTH + 1);

  back_state_t      state;
  back_state_t      state_next;
  pass_t            pass;
  status_t          rep_status;
  status_t          chk;
  logic [CNT_W-1:0] cnt [3];
  logic [ORD_W-1:0] last_ord [3];
  logic             order_bad;
  logic [CNT_W-1:0] pos [3];
  logic [CNT_W-1:0] n;
  logic [ORD_W-1:0] head [3];
  logic [TOT_W-1:0] tot;
  logic             list_err;
  logic             agg_err;
  logic [ORD_W-1:0] ld_ord;
  logic             ld_full;
  logic             ld_bad;
  logic [2:0]       act;
  logic [ORD_W-1:0] cand;
  logic [1:0]       head_hits;
  logic [1:0]       pick;
  logic             done;
  logic             out_free;
  logic             do_load;
  logic             start_fin;
  logic             advance;
  logic             dup_hit;
  logic             emit_elem;
  logic             emit_rep;
  logic             frame_clear;
  logic [2:0]       we;
  status_t          out_status;
  logic [ORD_W-1:0] out_ord;
  logic             out_last;

  assign status         = out_status;
  assign merged_ordinal = PORT_ORD_W'(out_ord);
  assign last           = out_last;
  assign out_free       = !out_valid || !out_stall;

  // frame checks
  always_comb begin
    tot = TOT_W'(cnt[0]) + TOT_W'(cnt[1]) + TOT_W'(cnt[2]);
    list_err = (cnt[0] > limits.max_a) || (cnt[0] > DEPTH_C) ||
               (cnt[1] > limits.max_b) || (cnt[1] > DEPTH_C) ||
               (cnt[2] > limits.max_c) || (cnt[2] > DEPTH_C);
    agg_err  = (tot > TOT_W'(limits.max_total)) || (tot > TOT_W'(RESULT_CAP));
    priority if (list_err) begin
      chk = ST_LIST_LIMIT;
    end else if (agg_err) begin
      chk = ST_AGG_LIMIT;
    end else if (order_bad) begin
      chk = ST_ORDER;
    end else if (tot == '0) begin
      chk = ST_EMPTY_OK;
    end else begin
      chk = ST_ELEMENT;
    end
  end

  always_comb begin
    ld_ord  = q_op.ord[ORD_W-1:0];
    ld_full = (cnt[q_op.sel] >= DEPTH_C);
    ld_bad  = (ld_ord == '0) || (ld_ord <= last_ord[q_op.sel]);
  end

  // smallest head and how many lists hold it
  always_comb begin
    logic have;
    have      = 1'b0;
    cand      = '0;
    head_hits = 2'd0;
    pick      = 2'd0;
    for (int i = 0; i < 3; i++) begin
      act[i] = (pos[i] < cnt[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (act[i] && (!have || head[i] < cand)) begin
        cand = head[i];
        have = 1'b1;
      end
    end
    for (int i = 2; i >= 0; i--) begin
      if (act[i] && head[i] == cand) begin
        head_hits = head_hits + 2'd1;
        pick      = 2'(i);
      end
    end
    done = ((TOT_W'(n) + TOT_W'(1)) == tot);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_op.kind == OP_FINISH) begin
          state_next = (chk == ST_ELEMENT) ? BK_READ : BK_REPORT;
        end
      end
      BK_READ: begin
        state_next = BK_CMP;
      end
      BK_CMP: begin
        if (pass == PASS_CHECK) begin
          state_next = (head_hits == 2'd1) ? BK_READ : BK_REPORT;
        end else if (out_free) begin
          state_next = done ? BK_IDLE : BK_READ;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    q_pop       = (state == BK_IDLE) && q_valid;
    do_load     = q_pop && (q_op.kind == OP_LOAD);
    start_fin   = q_pop && (q_op.kind == OP_FINISH);
    dup_hit     = (state == BK_CMP) && (pass == PASS_CHECK) && (head_hits != 2'd1);
    emit_elem   = (state == BK_CMP) && (pass == PASS_EMIT) && out_free;
    advance     = ((state == BK_CMP) && (pass == PASS_CHECK) && (head_hits == 2'd1)) ||
                  emit_elem;
    emit_rep    = (state == BK_REPORT) && out_free;
    frame_clear = emit_rep || (emit_elem && done);
    for (int i = 0; i < 3; i++) begin
      we[i] = do_load && !ld_full && (q_op.sel == 2'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pass      <= PASS_CHECK;
      n         <= '0;
      order_bad <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cnt[i]      <= '0;
        last_ord[i] <= '0;
        pos[i]      <= '0;
      end
    end else begin
      state <= state_next;
      if (start_fin) begin
        pass <= PASS_CHECK;
        n    <= '0;
        for (int i = 0; i < 3; i++) begin
          pos[i] <= '0;
        end
      end
      if (advance) begin
        if (done) begin
          pass <= PASS_EMIT;
          n    <= '0;
          for (int i = 0; i < 3; i++) begin
            pos[i] <= '0;
          end
        end else begin
          n         <= n + CNT_W'(1);
          pos[pick] <= pos[pick] + CNT_W'(1);
        end
      end
      if (do_load) begin
        if (ld_full) begin
          cnt[q_op.sel] <= FULL_C;
        end else begin
          cnt[q_op.sel]      <= cnt[q_op.sel] + CNT_W'(1);
          last_ord[q_op.sel] <= ld_ord;
          if (ld_bad) begin
            order_bad <= 1'b1;
          end
        end
      end
      if (frame_clear) begin
        order_bad <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          cnt[i]      <= '0;
          last_ord[i] <= '0;
        end
      end
      if (emit_elem || emit_rep) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_fin) begin
      rep_status <= chk;
    end
    if (dup_hit) begin
      rep_status <= ST_DUPLICATE;
    end
    if (emit_elem) begin
      out_status <= ST_ELEMENT;
      out_ord    <= cand;
      out_last   <= done;
    end
    if (emit_rep) begin
      out_status <= rep_status;
      out_ord    <= '0;
      out_last   <= 1'b1;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_list
    logic [ORD_W-1:0] mem [LIST_DEPTH];
    always_ff @(posedge clk) begin
      if (we[g]) begin
        mem[cnt[g][AW-1:0]] <= ld_ord;
      end
      head[g] <= mem[pos[g][AW-1:0]];
    end
  end

endmodule
